// ===== design/ps2mct_pkg.sv =====
package ps2mct_pkg;

    // status bit that marks a byte from the auxiliary (mouse) port
    localparam int AUX_BIT = 5;

    // standard mouse packet: header byte, x delta, y delta
    localparam int PACKET_LEN = 3;
    localparam logic [1:0] LAST_INDEX = 2'(PACKET_LEN - 1);

    // cursor position after reset
    localparam int START_X = 160;
    localparam int START_Y = 100;

    localparam int SIZE_BITS = 14;

    typedef enum logic [1:0] {
        CFG_DISPLAY_ENABLE = 2'd0,
        CFG_SCREEN_WIDTH   = 2'd1,
        CFG_SCREEN_HEIGHT  = 2'd2
    } cfg_index_t;

    // one completed packet, handed from the byte collector to the cursor logic
    typedef struct packed {
        logic       done;
        logic [2:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
    } pkt_t;

endpackage

// ===== design/ps2mct_if.sv =====
interface ps2mct_evt_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] data_byte;

    modport source (output valid, output status_byte, output data_byte, input ready);
    modport sink (input valid, input status_byte, input data_byte, output ready);
endinterface

interface ps2mct_res_if #(
    parameter int COORD_BITS = 13
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [2:0]            button_bits;
    logic                  packet_applied;

    modport source (
        output valid, output cursor_x, output cursor_y, output button_bits,
        output packet_applied, input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y, input button_bits,
        input packet_applied, output ready
    );
endinterface

// ===== design/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse cursor tracker. Each transfer on evt is one controller event (status byte
// and data byte); every event gives exactly one transfer on res, in order, showing the
// cursor and buttons after that event. Events without status bit 5 (auxiliary data) change
// nothing. Mouse bytes are grouped into three-byte packets; on the third byte, with
// display_enable set, the buttons are taken from the header bits 2..0, x moves by the
// signed x delta and y by minus the signed y delta, each clamped to 0..size-1 (a size
// above the coordinate range clamps at the range top). With display_enable clear the bytes
// are still counted but the packet is dropped. Sync and overflow bits are not checked.
// Timing: an event is caught in the input register at its transfer edge, worked through while
// it sits there and loaded into the result register at the next edge on which that register
// can take it; one event per cycle is sustained while res takes its transfers. With res
// stalled the two registers hold two events and then evt.ready drops. Configuration goes
// through cfg_we/cfg_index/cfg_data (0 display_enable, 1 screen_width, 2 screen_height) and
// must only be written while no event is in flight.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = 13
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_data,
    ps2mct_evt_if.sink           evt,
    ps2mct_res_if.source         res
);

    // input register: holds one accepted event
    logic       s1_valid_reg;
    logic [7:0] s1_status_reg;
    logic [7:0] s1_data_reg;

    // result register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [2:0]            out_buttons_reg;
    logic                  out_applied_reg;

    logic                  out_load;  // result register can take a new result
    logic                  fire;      // event in the input register is processed now
    logic                  display_enable;
    logic [COORD_BITS-1:0] x_bound;
    logic [COORD_BITS-1:0] y_bound;
    pkt_t                  pkt;
    logic [COORD_BITS-1:0] x_next;
    logic [COORD_BITS-1:0] y_next;
    logic [2:0]            buttons_next;
    logic                  applied;

    assign out_load  = !out_valid_reg || res.ready;
    assign fire      = s1_valid_reg && out_load;
    // input register refills in the same cycle it drains
    assign evt.ready = !s1_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            s1_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            s1_status_reg <= evt.status_byte;
            s1_data_reg   <= evt.data_byte;
        end
    end

    ps2mct_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .display_enable (display_enable),
        .x_bound        (x_bound),
        .y_bound        (y_bound)
    );

    // byte counter and first two packet bytes
    ps2mct_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .status_byte (s1_status_reg),
        .data_byte   (s1_data_reg),
        .pkt         (pkt)
    );

    // position and button state, add and clamp
    ps2mct_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .pkt            (pkt),
        .display_enable (display_enable),
        .x_bound        (x_bound),
        .y_bound        (y_bound),
        .x_next         (x_next),
        .y_next         (y_next),
        .buttons_next   (buttons_next),
        .applied        (applied)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_x_reg       <= x_next;
            out_y_reg       <= y_next;
            out_buttons_reg <= buttons_next;
            out_applied_reg <= applied;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.cursor_x       = out_x_reg;
    assign res.cursor_y       = out_y_reg;
    assign res.button_bits    = out_buttons_reg;
    assign res.packet_applied = out_applied_reg;

    // an applied packet only shows up while tracking is enabled
    a_applied_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.packet_applied) |-> display_enable)
        else $error("packet applied with tracking disabled");

    // after an applied packet the cursor sits inside the screen
    a_x_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.packet_applied) |-> (res.cursor_x <= x_bound))
        else $error("cursor x beyond screen after applied packet");

    a_y_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.packet_applied) |-> (res.cursor_y <= y_bound))
        else $error("cursor y beyond screen after applied packet");

endmodule

// ===== design/ps2mct_cfg.sv =====
module ps2mct_cfg
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = 13
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [SIZE_BITS-1:0]  cfg_data,
    output logic                  display_enable,
    output logic [COORD_BITS-1:0] x_bound,
    output logic [COORD_BITS-1:0] y_bound
);

    localparam int CMP_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS + 1;
    localparam logic [CMP_BITS-1:0] COORD_MAX = CMP_BITS'((2 ** COORD_BITS) - 1);

    // largest coordinate for a screen size: size-1, zero for size 0, capped at range
    function automatic logic [COORD_BITS-1:0] size_to_bound(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] m;
        logic [CMP_BITS-1:0]  m_ext;
        m     = (size == '0) ? '0 : size - SIZE_BITS'(1);
        m_ext = CMP_BITS'(m);
        return (m_ext > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : m_ext[COORD_BITS-1:0];
    endfunction

    logic                  enable_reg;
    logic [COORD_BITS-1:0] x_bound_reg;
    logic [COORD_BITS-1:0] y_bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            x_bound_reg <= size_to_bound(SIZE_BITS'(640));
            y_bound_reg <= size_to_bound(SIZE_BITS'(480));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE: enable_reg  <= cfg_data[0];
                CFG_SCREEN_WIDTH:   x_bound_reg <= size_to_bound(cfg_data);
                CFG_SCREEN_HEIGHT:  y_bound_reg <= size_to_bound(cfg_data);
                default:            ;
            endcase
        end
    end

    assign display_enable = enable_reg;
    assign x_bound        = x_bound_reg;
    assign y_bound        = y_bound_reg;

endmodule

// ===== design/ps2mct_packer.sv =====
module ps2mct_packer
    import ps2mct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_byte,
    output pkt_t       pkt
);

    logic [1:0] index_reg;
    logic [1:0] index_next;
    logic [7:0] byte0_reg;
    logic [7:0] byte1_reg;
    logic       aux;
    logic       last;

    assign aux  = fire && status_byte[AUX_BIT];
    assign last = (index_reg == LAST_INDEX);

    always_comb
    begin
        index_next = index_reg;
        if (aux)
        begin
            index_next = last ? 2'd0 : index_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= 2'd0;
        end
        else
        begin
            index_reg <= index_next;
        end
    end

    // header and x delta bytes, no reset
    always_ff @(posedge clk)
    begin
        if (aux && !last)
        begin
            if (index_reg[0])
            begin
                byte1_reg <= data_byte;
            end
            else
            begin
                byte0_reg <= data_byte;
            end
        end
    end

    assign pkt.done    = aux && last;
    assign pkt.buttons = byte0_reg[2:0];
    assign pkt.dx      = byte1_reg;
    assign pkt.dy      = data_byte;

endmodule

// ===== design/ps2mct_cursor.sv =====
module ps2mct_cursor
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = 13
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  pkt_t                  pkt,
    input  logic                  display_enable,
    input  logic [COORD_BITS-1:0] x_bound,
    input  logic [COORD_BITS-1:0] y_bound,
    output logic [COORD_BITS-1:0] x_next,
    output logic [COORD_BITS-1:0] y_next,
    output logic [2:0]            buttons_next,
    output logic                  applied
);

    localparam int W = COORD_BITS + 2;

    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [2:0]            buttons_reg;
    logic [W-1:0]          sum_x;
    logic [W-1:0]          sum_y;
    logic [COORD_BITS-1:0] clamp_x;
    logic [COORD_BITS-1:0] clamp_y;

    function automatic logic [COORD_BITS-1:0] clamp(
        input logic [W-1:0]          v,
        input logic [COORD_BITS-1:0] hi
    );
        logic [COORD_BITS-1:0] r;
        if (v[W-1])
        begin
            r = '0;
        end
        else if (v[W-2:0] > {1'b0, hi})
        begin
            r = hi;
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    // x moves by +dx, y by -dy (mouse y points up, screen y points down)
    assign sum_x = {2'b00, pos_x_reg} + {{(W-8){pkt.dx[7]}}, pkt.dx};
    assign sum_y = {2'b00, pos_y_reg} - {{(W-8){pkt.dy[7]}}, pkt.dy};

    assign clamp_x = clamp(sum_x, x_bound);
    assign clamp_y = clamp(sum_y, y_bound);

    assign applied      = fire && pkt.done && display_enable;
    assign x_next       = applied ? clamp_x : pos_x_reg;
    assign y_next       = applied ? clamp_y : pos_y_reg;
    assign buttons_next = applied ? pkt.buttons : buttons_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= COORD_BITS'(START_X);
            pos_y_reg   <= COORD_BITS'(START_Y);
            buttons_reg <= 3'd0;
        end
        else
        begin
            pos_x_reg   <= x_next;
            pos_y_reg   <= y_next;
            buttons_reg <= buttons_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import ps2mct_pkg::*;
;

    localparam int COORD_BITS  = 13;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int IDLE_PCT    = 26;      // chance of a gap on either side
    localparam int HOLD_AT     = 500;     // events accepted before the long receiver stall
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 300000;  // far above the slowest correct run
    localparam int NUM_PHASES  = 10;

    localparam logic [7:0] AUX_MASK = 8'(1 << AUX_BIT);

    // what one res transfer carries
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [2:0]            buttons;
        logic                  applied;
    } cursor_report_t;

    // direction the random deltas lean toward, so the cursor reaches the screen limits
    typedef enum int {
        DRIFT_NONE,
        DRIFT_UP,
        DRIFT_DOWN
    } drift_t;

    typedef struct {
        bit     en;
        int     width;
        int     height;
        drift_t drift;
        int     n_bytes;
    } screen_phase_t;

    // cursor predictor plus the queue of reports still owed by the block
    class cursor_scoreboard;
        bit                    track_en;
        logic [SIZE_BITS-1:0]  width_px;
        logic [SIZE_BITS-1:0]  height_px;
        logic [1:0]            byte_pos;
        logic [7:0]            held_bytes [2];
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [2:0]            buttons;
        cursor_report_t        pending_reports [$];
        int                    events_seen;
        int                    aux_bytes;
        int                    packets_applied;
        int                    reports_checked;
        int                    mismatches;

        function new();
            track_en      = 1'b0;
            width_px      = SIZE_BITS'(640);
            height_px     = SIZE_BITS'(480);
            byte_pos      = '0;
            held_bytes[0] = '0;
            held_bytes[1] = '0;
            pos_x         = COORD_BITS'(START_X);
            pos_y         = COORD_BITS'(START_Y);
            buttons       = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [SIZE_BITS-1:0] val);
            case (idx)
                CFG_DISPLAY_ENABLE: track_en  = val[0];
                CFG_SCREEN_WIDTH:   width_px  = val;
                CFG_SCREEN_HEIGHT:  height_px = val;
                default: ;
            endcase
        endfunction

        // highest coordinate on a screen of this size; zero size pins it at 0
        static function int top_coord(logic [SIZE_BITS-1:0] size);
            int lim;
            lim = (size == 0) ? 0 : int'(size) - 1;
            return (lim > COORD_MAX) ? COORD_MAX : lim;
        endfunction

        static function logic [COORD_BITS-1:0] clamp_coord(int v, int lim);
            if (v < 0)
                v = 0;
            if (v > lim)
                v = lim;
            return COORD_BITS'(v);
        endfunction

        function void advance_cursor(logic [7:0] status, logic [7:0] data);
            int   nx;
            int   ny;
            logic applied;
            applied = 1'b0;
            events_seen++;
            if (status[AUX_BIT]) begin
                aux_bytes++;
                if (byte_pos != LAST_INDEX) begin
                    held_bytes[byte_pos] = data;
                    byte_pos++;
                end else begin
                    byte_pos = '0;
                    if (track_en) begin
                        nx      = int'(pos_x) + int'($signed(held_bytes[1]));
                        ny      = int'(pos_y) - int'($signed(data));
                        buttons = held_bytes[0][2:0];
                        pos_x   = clamp_coord(nx, top_coord(width_px));
                        pos_y   = clamp_coord(ny, top_coord(height_px));
                        applied = 1'b1;
                        packets_applied++;
                    end
                end
            end
            pending_reports.push_back('{pos_x, pos_y, buttons, applied});
        endfunction

        function void check_report(cursor_report_t got);
            cursor_report_t want;
            reports_checked++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report %0d with nothing pending: x=%0d y=%0d buttons=%b applied=%b",
                             reports_checked, got.x, got.y, got.buttons, got.applied);
                return;
            end
            want = pending_reports.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.buttons !== want.buttons ||
                got.applied !== want.applied) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("report %0d mismatch: expected x=%0d y=%0d buttons=%b applied=%b",
                             reports_checked, want.x, want.y, want.buttons, want.applied);
                    $display("    got x=%0d y=%0d buttons=%b applied=%b",
                             got.x, got.y, got.buttons, got.applied);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [SIZE_BITS-1:0] cfg_data;

    bit steady;          // no gaps on either side while set
    bit hold_done;
    int cycle_count;
    int settings_used;

    cursor_scoreboard sb = new();
    screen_phase_t    phases [NUM_PHASES];

    ps2mct_evt_if evt_ch ();
    ps2mct_res_if #(.COORD_BITS(COORD_BITS)) res_ch ();

    ps2_mouse_cursor_tracker #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // both channels are sampled at the rising edge, before the block updates anything;
    // the input transfer is noted first in case a report ever came out in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_ch.valid && evt_ch.ready)
                sb.advance_cursor(evt_ch.status_byte, evt_ch.data_byte);
            if (res_ch.valid && res_ch.ready)
                sb.check_report('{res_ch.cursor_x, res_ch.cursor_y, res_ch.button_bits,
                                  res_ch.packet_applied});
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports still pending",
                     cycle_count, sb.pending_reports.size());
            $display("** ps2_mouse_cursor_tracker: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off once enough events went in,
    // so the input side backs up while the sender keeps offering
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.events_seen >= HOLD_AT)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer;
    // valid stays high between back-to-back events
    task automatic send_event(input logic [7:0] status, input logic [7:0] data);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            evt_ch.valid = 1'b0;
            @(negedge clk);
        end
        evt_ch.valid       = 1'b1;
        evt_ch.status_byte = status;
        evt_ch.data_byte   = data;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // byte from the mouse port, other status bits random
    task automatic send_mouse_byte(input logic [7:0] data);
        send_event(8'($urandom) | AUX_MASK, data);
    endtask

    // controller event from elsewhere, ignored by the block
    task automatic send_other_event();
        send_event(8'($urandom) & ~AUX_MASK, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_delta(drift_t drift);
        if (drift != DRIFT_NONE && $urandom_range(0, 99) < 85)
            return (drift == DRIFT_UP) ? 8'($urandom_range(96, 127))
                                       : 8'($urandom_range(128, 159));
        return 8'($urandom);
    endfunction

    // block has to be idle: nothing pending and the pipeline drained
    task automatic wait_idle();
        evt_ch.valid = 1'b0;
        while (sb.pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [SIZE_BITS-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic apply_settings(input bit en, input int width, input int height);
        wait_idle();
        write_reg(CFG_DISPLAY_ENABLE, SIZE_BITS'(en));
        write_reg(CFG_SCREEN_WIDTH, SIZE_BITS'(width));
        write_reg(CFG_SCREEN_HEIGHT, SIZE_BITS'(height));
        cfg_we = 1'b0;
        settings_used++;
    endtask

    // mostly whole packets with random content; stray mouse bytes knock the
    // framing off, foreign events sometimes land inside a packet
    task automatic run_phase(input screen_phase_t ph);
        int     sent;
        int     roll;
        drift_t ydrift;
        // y moves by minus the delta, so lean the other way to push it the same direction
        ydrift = (ph.drift == DRIFT_UP) ? DRIFT_DOWN :
                 (ph.drift == DRIFT_DOWN) ? DRIFT_UP : DRIFT_NONE;
        apply_settings(ph.en, ph.width, ph.height);
        sent = 0;
        while (sent < ph.n_bytes)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                send_mouse_byte(8'($urandom));
                if ($urandom_range(0, 99) < 5)
                    send_other_event();
                send_mouse_byte(pick_delta(ph.drift));
                send_mouse_byte(pick_delta(ydrift));
                sent += 3;
            end
            else if (roll < 90)
            begin
                send_mouse_byte(8'($urandom));
                sent++;
            end
            else
            begin
                send_other_event();
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_DISPLAY_ENABLE;
        cfg_data           = '0;
        evt_ch.valid       = 1'b0;
        evt_ch.status_byte = '0;
        evt_ch.data_byte   = '0;
        settings_used      = 1;

        // screen settings per random phase: limits above the coordinate range,
        // exactly at it, a one-pixel screen right after the cursor was pushed toward 0,
        // zero size, tracking off, and two drawn at random
        phases[0] = '{1'b1, 640, 480, DRIFT_NONE, 280};
        phases[1] = '{1'b1, 16383, 16383, DRIFT_UP, 300};
        phases[2] = '{1'b1, 8192, 8192, DRIFT_UP, 150};
        phases[3] = '{1'b1, 16383, 16383, DRIFT_DOWN, 300};
        phases[4] = '{1'b1, 1, 1, DRIFT_NONE, 100};
        phases[5] = '{1'b1, 0, 0, DRIFT_NONE, 100};
        phases[6] = '{1'b0, 300, 200, DRIFT_NONE, 150};
        phases[7] = '{1'b1, 300, 200, DRIFT_UP, 150};
        phases[8] = '{1'b1, $urandom_range(1, 2000), $urandom_range(1, 2000), DRIFT_NONE, 150};
        phases[9] = '{1'($urandom_range(0, 1)), $urandom_range(0, 16383),
                      $urandom_range(0, 16383), DRIFT_DOWN, 150};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // events without the aux bit leave everything alone
        send_event(8'h00, 8'hFF);
        send_event(~AUX_MASK, 8'h00);
        // full packet while tracking is off after reset: counted but dropped
        send_event(AUX_MASK, 8'h07);
        send_event(8'hFF, 8'h7F);
        send_event(AUX_MASK, 8'h80);

        apply_settings(1'b1, 640, 480);
        // header with sync and overflow bits set, all buttons; largest +x, most negative y
        send_event(8'hFF, 8'hFF);
        send_event(AUX_MASK, 8'h7F);
        send_event(AUX_MASK, 8'h80);
        // most negative x, largest y delta
        send_event(AUX_MASK, 8'h08);
        send_event(AUX_MASK, 8'h80);
        send_event(AUX_MASK, 8'h7F);
        // foreign event in the middle of a packet, y clamps at the top
        send_event(AUX_MASK, 8'h0A);
        send_event(8'h1F, 8'hAA);
        send_event(AUX_MASK, 8'h80);
        send_event(AUX_MASK, 8'h7F);
        // x clamps at the left edge
        send_event(AUX_MASK, 8'h0C);
        send_event(AUX_MASK, 8'h80);
        send_event(AUX_MASK, 8'h80);
        // zero motion
        send_event(AUX_MASK, 8'h01);
        send_event(AUX_MASK, 8'h00);
        send_event(AUX_MASK, 8'h00);

        for (int i = 0; i < NUM_PHASES; i++)
        begin
            steady = (i == 0);
            run_phase(phases[i]);
        end
        steady = 1'b0;

        wait_idle();
        repeat (4) @(negedge clk);

        $display("run covered %0d events (%0d mouse bytes), %0d packets applied",
                 sb.events_seen, sb.aux_bytes, sb.packets_applied);
        $display("%0d screen settings, %0d reports checked, long receiver hold-off %0s",
                 settings_used, sb.reports_checked, hold_done ? "done" : "missed");
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
        begin
            $display("** ps2_mouse_cursor_tracker: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("** ps2_mouse_cursor_tracker: FAILED **");
        end
        $finish;
    end

endmodule

// ===== ps2_mouse_cursor_tracker.f =====
design/ps2mct_pkg.sv
design/ps2mct_if.sv
design/ps2mct_cfg.sv
design/ps2mct_packer.sv
design/ps2mct_cursor.sv
design/ps2_mouse_cursor_tracker.sv
tb/testbench.sv
